/* rtl/core/rletd_pkg.sv */
`timescale 1ns / 1ps
// rletd_pkg: types and constants for the run-length token decoder
// no dependencies; imported by every module of the decoder
package rletd_pkg;

   localparam int MAX_RESULTS = 64;
   localparam int NRES_W      = 6;

   localparam logic [7:0] TYPE_RUN = 8'h00;
   localparam logic [7:0] TYPE_LIT = 8'h01;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_TRUNC   = 2'd1;
   localparam logic [1:0] STAT_BADTYPE = 2'd2;

   typedef enum logic [1:0] {
      PH_TYPE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2,
      PH_LIT   = 2'd3
   } phase_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic [2:0]  byte_count;
      logic [1:0]  status;
      logic        burst_last;
      logic        stream_end;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic run_start;
      logic run_final;
   } stat_type;

endpackage

/* rtl/core/rletd_ctrl.sv */
`timescale 1ns / 1ps
// rletd_ctrl: sequencer that accepts tokens and runs word expansion
// depends on rletd_pkg
module rletd_ctrl
   import rletd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.out_free && stat.run_start) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free && stat.run_final) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd.accept = 1'b0;
      cmd.emit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = !stat.out_free;
            cmd.accept = req_valid && stat.out_free;
         end
         ST_EMIT: begin
            cmd.emit = stat.out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

endmodule

/* rtl/core/rletd_datapath.sv */
`timescale 1ns / 1ps
// rletd_datapath: token state, run expansion registers and result register
// depends on rletd_pkg
module rletd_datapath
   import rletd_pkg::*;
#(
   parameter int LANES = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam logic [7:0] LANES_B = 8'(LANES);

   phase_type         phase_ff, phase_in;
   logic [7:0]        remaining_ff, remaining_in;
   logic [1:0]        err_ff, err_in;
   logic [7:0]        value_ff, value_in;
   logic [7:0]        left_ff, left_in;
   logic [NRES_W-1:0] nres_ff, nres_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [7:0]  cnt;
   logic [31:0] run_word;
   logic        has_data;
   logic [7:0]  rem_dec;
   logic [1:0]  fin_err;

   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;
   assign stat.run_start = (err_ff == STAT_OK) && (phase_ff == PH_VALUE) &&
                           (remaining_ff != 8'd0);
   assign stat.run_final = (left_ff <= LANES_B) ||
                           (nres_ff == NRES_W'(MAX_RESULTS - 1));

   assign cnt      = (left_ff < LANES_B) ? left_ff : LANES_B;
   assign has_data = (err_ff == STAT_OK) && (phase_ff == PH_LIT);
   assign rem_dec  = remaining_ff - 8'd1;

   always_comb begin
      run_word = '0;
      for (int k = 0; k < 4; k++) begin
         if (8'(k) < cnt) begin
            run_word[8*k +: 8] = value_ff;
         end
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      err_in       = err_ff;
      value_in     = value_ff;
      left_in      = left_ff;
      nres_in      = nres_ff;
      last_in      = last_ff;
      fin_err      = STAT_OK;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.accept) begin
         if (err_ff == STAT_OK) begin
            unique case (phase_ff)
               PH_TYPE: begin
                  if (req_data.data_byte == TYPE_RUN || req_data.data_byte == TYPE_LIT) begin
                     remaining_in = req_data.data_byte;
                     phase_in     = PH_LEN;
                  end else begin
                     err_in       = STAT_BADTYPE;
                     phase_in     = PH_TYPE;
                     remaining_in = 8'd0;
                  end
               end
               PH_LEN: begin
                  remaining_in = req_data.data_byte;
                  if (remaining_ff == TYPE_RUN) begin
                     phase_in = PH_VALUE;
                  end else if (req_data.data_byte == 8'd0) begin
                     phase_in = PH_TYPE;
                  end else begin
                     phase_in = PH_LIT;
                  end
               end
               PH_VALUE: begin
                  remaining_in = 8'd0;
                  phase_in     = PH_TYPE;
                  left_in      = remaining_ff;
                  value_in     = req_data.data_byte;
                  nres_in      = '0;
                  last_in      = req_data.last_byte;
               end
               PH_LIT: begin
                  remaining_in = rem_dec;
                  if (rem_dec == 8'd0) begin
                     phase_in = PH_TYPE;
                  end
               end
               default: phase_in = PH_TYPE;
            endcase
         end

         if (req_data.last_byte) begin
            fin_err = err_in;
            if (err_in == STAT_OK && phase_in != PH_TYPE) begin
               fin_err = STAT_TRUNC;
            end
            phase_in     = PH_TYPE;
            remaining_in = 8'd0;
            err_in       = STAT_OK;
         end

         if (!stat.run_start && (has_data || req_data.last_byte)) begin
            rsp_valid_in        = 1'b1;
            rsp_in.out_word     = has_data ? {24'd0, req_data.data_byte} : 32'd0;
            rsp_in.byte_count   = has_data ? 3'd1 : 3'd0;
            rsp_in.status       = req_data.last_byte ? fin_err : STAT_OK;
            rsp_in.burst_last   = 1'b1;
            rsp_in.stream_end   = req_data.last_byte;
         end
      end else if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.out_word   = run_word;
         rsp_in.byte_count = cnt[2:0];
         rsp_in.status     = STAT_OK;
         rsp_in.burst_last = stat.run_final;
         rsp_in.stream_end = stat.run_final && last_ff;
         left_in           = left_ff - cnt;
         nres_in           = nres_ff + NRES_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         remaining_ff <= 8'd0;
         err_ff       <= STAT_OK;
         rsp_valid_ff <= 1'b0;
         nres_ff      <= '0;
         left_ff      <= 8'd0;
         last_ff      <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         nres_ff      <= nres_in;
         left_ff      <= left_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/rle_token_decoder.sv */
`timescale 1ns / 1ps
// rle_token_decoder: run-length token stream decoder, one encoded byte a transaction
// depends on rletd_pkg, rletd_ctrl, rletd_datapath
//
// usage:
//   req channel carries one byte of the token stream plus a last flag; rsp channel
//   carries result words of up to LANES bytes (lanes 0 to 3 visible), a lane count,
//   the stream status and burst/stream end flags
//   a type or length byte gives no result unless it is the last byte; a literal
//   byte gives one result, registered and shown in the cycle after acceptance
//   a run value byte then holds the input while its result words are emitted one
//   at a time, min(64, ceil(length / LANES)) words, by the single word emit path;
//   a byte that gives a result or none is accepted every cycle while the result
//   register is free; that register lets the next byte enter while a result waits,
//   so with no stall the sustained rate is one byte a cycle outside run expansion
//   rsp_stall holds the result register; req_stall rises while it is full and
//   stalled, and during run expansion
//   synchronous reset returns the decoder to expect a token type, clears the
//   sticky error and drops any pending result
module rle_token_decoder
   import rletd_pkg::*;
#(
   parameter int LANES = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   rletd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rletd_datapath #(
      .LANES (LANES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/rletd_checker.sv */
`timescale 1ns / 1ps
// rletd_checker: port-level assertions for the run-length token decoder
// depends on rletd_pkg; bound to rle_token_decoder
module rletd_checker
   import rletd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_end_closes_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stream_end |-> rsp_data.burst_last)
      else $error("stream end without burst last");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.stream_end |-> rsp_data.status == STAT_OK)
      else $error("status set before stream end");

   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_count == 3'd0 |->
         rsp_data.stream_end && rsp_data.out_word == 32'd0)
      else $error("empty result that is not a bare stream end");

   // a last byte gives a result at once or starts run expansion
   a_last_gives_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_byte |=> rsp_valid || req_stall)
      else $error("last byte gave no result");

endmodule

bind rle_token_decoder rletd_checker u_rletd_checker (.*);

/* sim/rle_token_decoder_tb.sv */
`timescale 1ns / 1ps
// rle_token_decoder_tb: self-checking bench for the run-length token decoder
// depends on rletd_pkg and rle_token_decoder; directed table, then random token streams
// each result transaction is checked against the directed table or a behavioral decoder model of the bench
module rle_token_decoder_tb;
   import rletd_pkg::*;

   localparam int LANES         = 4;
   localparam int RANDOM_ITEMS  = 400;
   localparam int HOLD_AT       = 120;
   localparam int PAUSE_AT      = 260;
   localparam int QUIET_AT      = 340;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int MAX_PRINTED   = 40;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } directed_row_type;

   localparam rsp_type NO_RSP      = '0;
   localparam rsp_type END_TRUNC   = '{32'h0, 3'd0, STAT_TRUNC, 1'b1, 1'b1};
   localparam rsp_type END_BADTYPE = '{32'h0, 3'd0, STAT_BADTYPE, 1'b1, 1'b1};
   localparam rsp_type LIT_TRUNC   = '{32'h22, 3'd1, STAT_TRUNC, 1'b1, 1'b1};

   localparam directed_row_type DIRECTED [24] = '{
      '{'{8'h01, 1'b1}, 1'b1, END_TRUNC},
      '{'{8'h07, 1'b1}, 1'b1, END_BADTYPE},
      '{'{TYPE_RUN, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h00, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hAB, 1'b0}, 1'b0, NO_RSP},
      '{'{TYPE_LIT, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h02, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h00, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hFF, 1'b0}, 1'b0, NO_RSP},
      '{'{TYPE_RUN, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hFF, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h5A, 1'b0}, 1'b0, NO_RSP},
      '{'{TYPE_RUN, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h05, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h3C, 1'b1}, 1'b0, NO_RSP},
      '{'{TYPE_LIT, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h00, 1'b0}, 1'b0, NO_RSP},
      '{'{TYPE_LIT, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h03, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h11, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h22, 1'b1}, 1'b1, LIT_TRUNC},
      '{'{8'h09, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h01, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h55, 1'b1}, 1'b1, END_BADTYPE}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   phase_type  dec_phase = PH_TYPE;
   logic [7:0] dec_left  = '0;
   logic [1:0] dec_error = STAT_OK;

   rsp_type decoded_words[$];
   rsp_type expected_rsp[$];
   req_type stream_q[$];
   rsp_type want_rsp;

   int   mismatch_count = 0;
   int   cycle_count    = 0;
   int   hold_requests  = 0;
   int   hold_served    = 0;
   int   hold_left      = 0;
   int   stall_run_left = 0;
   logic quiet_tail     = 1'b0;

   rle_token_decoder #(.LANES(LANES)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTED) begin
         $display("tb: mismatch on %s at cycle %0d: got %h, want %h",
                  field, cycle_count, got, want);
      end
      mismatch_count++;
   endtask

   function automatic void decode_byte(input req_type item);
      logic [7:0] b;
      int         left;
      int         cnt;
      rsp_type    r;
      b = item.data_byte;
      decoded_words.delete();
      if (dec_error == STAT_OK) begin
         case (dec_phase)
            PH_TYPE: begin
               if (b == TYPE_RUN || b == TYPE_LIT) begin
                  dec_left  = b;
                  dec_phase = PH_LEN;
               end else begin
                  dec_error = STAT_BADTYPE;
                  dec_phase = PH_TYPE;
                  dec_left  = '0;
               end
            end
            PH_LEN: begin
               if (dec_left == TYPE_RUN) dec_phase = PH_VALUE;
               else dec_phase = (b == 8'h00) ? PH_TYPE : PH_LIT;
               dec_left = b;
            end
            PH_VALUE: begin
               left = int'(dec_left);
               while (left > 0 && decoded_words.size() < MAX_RESULTS) begin
                  cnt = (left < LANES) ? left : LANES;
                  r = '0;
                  for (int k = 0; k < cnt && k < 4; k++) r.out_word[8*k +: 8] = b;
                  r.byte_count = 3'(cnt);
                  decoded_words.insert(decoded_words.size(), r);
                  left -= cnt;
               end
               dec_left  = '0;
               dec_phase = PH_TYPE;
            end
            default: begin
               r = '0;
               r.out_word   = {24'h0, b};
               r.byte_count = 3'd1;
               decoded_words.insert(decoded_words.size(), r);
               dec_left = dec_left - 8'd1;
               if (dec_left == 8'd0) dec_phase = PH_TYPE;
            end
         endcase
      end
      if (item.last_byte) begin
         if (dec_error == STAT_OK && dec_phase != PH_TYPE) dec_error = STAT_TRUNC;
         if (decoded_words.size() == 0) decoded_words.insert(0, NO_RSP);
         r = decoded_words.pop_back();
         r.status     = dec_error;
         r.stream_end = 1'b1;
         decoded_words.insert(decoded_words.size(), r);
         dec_phase = PH_TYPE;
         dec_left  = '0;
         dec_error = STAT_OK;
      end
      if (decoded_words.size() != 0) begin
         r = decoded_words.pop_back();
         r.burst_last = 1'b1;
         decoded_words.insert(decoded_words.size(), r);
      end
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input req_type item, input logic typed, input rsp_type want);
      int gap;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 7);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(item);
      if (typed) begin
         expected_rsp.insert(expected_rsp.size(), want);
      end else begin
         foreach (decoded_words[i]) expected_rsp.insert(expected_rsp.size(), decoded_words[i]);
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_byte(input logic [7:0] b);
      req_type item;
      item.data_byte = b;
      item.last_byte = 1'b0;
      stream_q.insert(stream_q.size(), item);
   endtask

   task automatic build_stream();
      int      tokens;
      int      kind;
      int      len;
      int      cut;
      req_type item;
      stream_q.delete();
      tokens = $urandom_range(1, 4);
      repeat (tokens) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
            push_byte(TYPE_RUN);
            push_byte(8'(len));
            push_byte(8'($urandom_range(0, 255)));
         end else if (kind < 9) begin
            len = $urandom_range(0, 6);
            push_byte(TYPE_LIT);
            push_byte(8'(len));
            repeat (len) push_byte(8'($urandom_range(0, 255)));
         end else begin
            push_byte(8'($urandom_range(0, 255)));
         end
      end
      // cut the stream short now and then, ending mid-token
      if ($urandom_range(0, 7) == 0 && stream_q.size() > 1) begin
         cut = $urandom_range(1, stream_q.size() - 1);
         repeat (cut) void'(stream_q.pop_back());
      end
      item = stream_q.pop_back();
      item.last_byte = 1'b1;
      stream_q.insert(stream_q.size(), item);
   endtask

   // receiver stall: random bursts, one long hold on request, none in the tail
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else if (quiet_tail) begin
         rsp_stall <= 1'b0;
      end else if (stall_run_left > 0) begin
         stall_run_left <= stall_run_left - 1;
      end else if (!rsp_stall && $urandom_range(0, 3) == 0) begin
         rsp_stall      <= 1'b1;
         stall_run_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall      <= 1'b0;
         stall_run_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 9);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_data.out_word, 32'h0);
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (rsp_data.out_word !== want_rsp.out_word)
               report_mismatch("out_word", rsp_data.out_word, want_rsp.out_word);
            if (rsp_data.byte_count !== want_rsp.byte_count)
               report_mismatch("byte_count", 32'(rsp_data.byte_count),
                               32'(want_rsp.byte_count));
            if (rsp_data.status !== want_rsp.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want_rsp.status));
            if (rsp_data.burst_last !== want_rsp.burst_last)
               report_mismatch("burst_last", 32'(rsp_data.burst_last),
                               32'(want_rsp.burst_last));
            if (rsp_data.stream_end !== want_rsp.stream_end)
               report_mismatch("stream_end", 32'(rsp_data.stream_end),
                               32'(want_rsp.stream_end));
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      int   random_sent;
      logic hold_started;
      logic pause_done;
      random_sent  = 0;
      hold_started = 1'b0;
      pause_done   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
      wait_drained();

      while (random_sent < RANDOM_ITEMS) begin
         build_stream();
         foreach (stream_q[i]) begin
            if (!hold_started && random_sent >= HOLD_AT) begin
               hold_started = 1'b1;
               hold_requests++;
            end
            if (!pause_done && random_sent >= PAUSE_AT) begin
               pause_done = 1'b1;
               wait_drained();
            end
            if (random_sent >= QUIET_AT) quiet_tail = 1'b1;
            // bytes swallowed after an error do not count
            if (dec_error == STAT_OK || stream_q[i].last_byte) random_sent++;
            send_item(stream_q[i], 1'b0, NO_RSP);
         end
      end
      wait_drained();

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
